/* design/rtc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar clock package
// Shared types, action codes and calendar lookup tables.
// ----------------------------------------------------------------------------
package rtc_pkg;

   localparam int BASE_YEAR = 2000;

   localparam logic [2:0] ACT_TICK     = 3'd0;
   localparam logic [2:0] ACT_MIN_UP   = 3'd1;
   localparam logic [2:0] ACT_MIN_DOWN = 3'd2;
   localparam logic [2:0] ACT_DAY_UP   = 3'd3;
   localparam logic [2:0] ACT_DAY_DOWN = 3'd4;
   localparam logic [2:0] ACT_SET      = 3'd5;

   localparam logic [4:0] HOUR_LAST   = 5'd23;
   localparam logic [4:0] HOUR_NOON   = 5'd12;
   localparam logic [5:0] MINUTE_LAST = 6'd59;
   localparam logic [4:0] DAY_FIRST   = 5'd1;
   localparam logic [3:0] MONTH_FIRST = 4'd1;
   localparam logic [3:0] MONTH_FEB   = 4'd2;
   localparam logic [3:0] MONTH_LAST  = 4'd12;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_MIN_UP,
      OP_MIN_DOWN,
      OP_DAY_UP,
      OP_DAY_DOWN,
      OP_SET,
      OP_NONE
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic [4:0] day;
      logic [3:0] month;
      logic [7:0] year;
   } cmd_type;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic [3:0] hours_twelve;
      logic       is_pm;
      logic [4:0] day;
      logic [3:0] month;
      logic [7:0] year;
      logic [2:0] weekday;
   } rsp_type;

   typedef logic [2:0] year_wday_type  [256];
   typedef logic [2:0] month_wday_type [16];
   typedef logic [2:0] mod7_table_type [64];

   function automatic logic is_leap_year(input int full_year);
      logic leap;
      if (full_year % 4 != 0) begin
         leap = 1'b0;
      end else if (full_year % 100 != 0) begin
         leap = 1'b1;
      end else begin
         leap = (full_year % 400 == 0);
      end
      return leap;
   endfunction

   function automatic logic [255:0] build_leap_table();
      logic [255:0] t;
      t = '0;
      for (int i = 0; i < 256; i++) begin
         t[i] = is_leap_year(BASE_YEAR + i);
      end
      return t;
   endfunction

   // Year part of the day number mod 7; early selects January/February.
   function automatic year_wday_type build_year_wday(input int early);
      year_wday_type t;
      int y;
      int j;
      for (int i = 0; i < 256; i++) begin
         y = BASE_YEAR + i + 4800 - early;
         j = 365 * y + y / 4 - y / 100 + y / 400 - 32045;
         t[i] = 3'(j % 7);
      end
      return t;
   endfunction

   function automatic month_wday_type build_month_wday();
      month_wday_type t;
      int a;
      int mm;
      for (int m = 0; m < 16; m++) begin
         if (m >= 1 && m <= 12) begin
            a = (14 - m) / 12;
            mm = m + 12 * a - 3;
            t[m] = 3'(((153 * mm + 2) / 5) % 7);
         end else begin
            t[m] = 3'd0;
         end
      end
      return t;
   endfunction

   function automatic mod7_table_type build_mod7();
      mod7_table_type t;
      for (int i = 0; i < 64; i++) begin
         t[i] = 3'(i % 7);
      end
      return t;
   endfunction

   localparam logic [255:0]   LEAP_TABLE      = build_leap_table();
   localparam year_wday_type  YEAR_WDAY_EARLY = build_year_wday(1);
   localparam year_wday_type  YEAR_WDAY_LATE  = build_year_wday(0);
   localparam month_wday_type MONTH_WDAY      = build_month_wday();
   localparam mod7_table_type MOD7_TABLE      = build_mod7();

   function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      case (month) inside
         MONTH_FEB:                  days = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:    days = 5'd30;
         default:                    days = 5'd31;
      endcase
      return days;
   endfunction

endpackage
`default_nettype wire

/* design/rtc_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar clock queue
// Small first-in first-out register queue, full and empty flags.
// ----------------------------------------------------------------------------
module rtc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

/* design/rtc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar clock front end
// Accepts requests, decodes the action and saturates the set values.
// ----------------------------------------------------------------------------
module rtc_front (
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [2:0] req_action,
   input  wire logic [4:0] req_set_hours,
   input  wire logic [5:0] req_set_minutes,
   input  wire logic [5:0] req_set_seconds,
   input  wire logic [4:0] req_set_day,
   input  wire logic [3:0] req_set_month,
   input  wire logic [7:0] req_set_year,
   output logic            cmd_push,
   output rtc_pkg::cmd_type cmd,
   input  wire logic       cmd_full
);
   import rtc_pkg::*;

   logic [3:0] month_sat;
   logic [4:0] day_lim;

   assign req_full = cmd_full;
   assign cmd_push = req_push & ~cmd_full;

   always_comb begin
      if (req_set_month < MONTH_FIRST) begin
         month_sat = MONTH_FIRST;
      end else if (req_set_month > MONTH_LAST) begin
         month_sat = MONTH_LAST;
      end else begin
         month_sat = req_set_month;
      end
      day_lim = days_in_month(month_sat, LEAP_TABLE[req_set_year]);

      unique case (req_action)
         ACT_TICK:     cmd.op = OP_TICK;
         ACT_MIN_UP:   cmd.op = OP_MIN_UP;
         ACT_MIN_DOWN: cmd.op = OP_MIN_DOWN;
         ACT_DAY_UP:   cmd.op = OP_DAY_UP;
         ACT_DAY_DOWN: cmd.op = OP_DAY_DOWN;
         ACT_SET:      cmd.op = OP_SET;
         default:      cmd.op = OP_NONE;
      endcase

      cmd.hours   = (req_set_hours > HOUR_LAST) ? HOUR_LAST : req_set_hours;
      cmd.minutes = (req_set_minutes > MINUTE_LAST) ? MINUTE_LAST : req_set_minutes;
      cmd.seconds = (req_set_seconds > MINUTE_LAST) ? MINUTE_LAST : req_set_seconds;
      cmd.month   = month_sat;
      cmd.year    = req_set_year;
      if (req_set_day < DAY_FIRST) begin
         cmd.day = DAY_FIRST;
      end else if (req_set_day > day_lim) begin
         cmd.day = day_lim;
      end else begin
         cmd.day = req_set_day;
      end
   end

endmodule
`default_nettype wire

/* design/rtc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar clock back end
// Holds time and date, applies one transaction a cycle while a command waits and the response
// queue has room, forms the report.
module rtc_back (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire rtc_pkg::cmd_type cmd,
   input  wire logic       cmd_empty,
   output logic            cmd_pop,
   input  wire logic       rsp_full,
   output logic            rsp_push,
   output rtc_pkg::rsp_type rsp
);
   import rtc_pkg::*;

   logic [4:0] hours_ff,   hours_in;
   logic [5:0] minutes_ff, minutes_in;
   logic [5:0] seconds_ff, seconds_in;
   logic [4:0] day_ff,     day_in;
   logic [3:0] month_ff,   month_in;
   logic [7:0] year_ff,    year_in;

   logic       fire;
   logic [4:0] dim_cur;
   logic [4:0] fwd_day;
   logic [3:0] fwd_month;
   logic [7:0] fwd_year;
   logic [3:0] prev_month;
   logic [7:0] prev_year;
   logic [4:0] bwd_day;
   logic [3:0] bwd_month;
   logic [7:0] bwd_year;
   logic [2:0] year_wday;
   logic [5:0] wday_sum;

   assign fire     = ~cmd_empty & ~rsp_full;
   assign cmd_pop  = fire;
   assign rsp_push = fire;

   always_comb begin
      dim_cur = days_in_month(month_ff, LEAP_TABLE[year_ff]);
      if (day_ff < dim_cur) begin
         fwd_day   = day_ff + 1'b1;
         fwd_month = month_ff;
         fwd_year  = year_ff;
      end else begin
         fwd_day = DAY_FIRST;
         if (month_ff >= MONTH_LAST) begin
            fwd_month = MONTH_FIRST;
            fwd_year  = year_ff + 1'b1;
         end else begin
            fwd_month = month_ff + 1'b1;
            fwd_year  = year_ff;
         end
      end

      if (month_ff <= MONTH_FIRST) begin
         prev_month = MONTH_LAST;
         prev_year  = year_ff - 1'b1;
      end else begin
         prev_month = month_ff - 1'b1;
         prev_year  = year_ff;
      end
      if (day_ff > DAY_FIRST) begin
         bwd_day   = day_ff - 1'b1;
         bwd_month = month_ff;
         bwd_year  = year_ff;
      end else begin
         bwd_day   = days_in_month(prev_month, LEAP_TABLE[prev_year]);
         bwd_month = prev_month;
         bwd_year  = prev_year;
      end
   end

   always_comb begin
      hours_in   = hours_ff;
      minutes_in = minutes_ff;
      seconds_in = seconds_ff;
      day_in     = day_ff;
      month_in   = month_ff;
      year_in    = year_ff;
      if (fire) begin
         unique case (cmd.op)
            OP_TICK: begin
               if (seconds_ff != MINUTE_LAST) begin
                  seconds_in = seconds_ff + 1'b1;
               end else begin
                  seconds_in = '0;
                  if (minutes_ff != MINUTE_LAST) begin
                     minutes_in = minutes_ff + 1'b1;
                  end else begin
                     minutes_in = '0;
                     if (hours_ff != HOUR_LAST) begin
                        hours_in = hours_ff + 1'b1;
                     end else begin
                        hours_in = '0;
                        day_in   = fwd_day;
                        month_in = fwd_month;
                        year_in  = fwd_year;
                     end
                  end
               end
            end
            OP_MIN_UP: begin
               seconds_in = '0;
               if (minutes_ff >= MINUTE_LAST) begin
                  minutes_in = '0;
                  hours_in   = (hours_ff >= HOUR_LAST) ? '0 : hours_ff + 1'b1;
               end else begin
                  minutes_in = minutes_ff + 1'b1;
               end
            end
            OP_MIN_DOWN: begin
               seconds_in = '0;
               if (minutes_ff == '0) begin
                  minutes_in = MINUTE_LAST;
                  hours_in   = (hours_ff == '0) ? HOUR_LAST : hours_ff - 1'b1;
               end else begin
                  minutes_in = minutes_ff - 1'b1;
               end
            end
            OP_DAY_UP: begin
               day_in   = fwd_day;
               month_in = fwd_month;
               year_in  = fwd_year;
            end
            OP_DAY_DOWN: begin
               day_in   = bwd_day;
               month_in = bwd_month;
               year_in  = bwd_year;
            end
            OP_SET: begin
               hours_in   = cmd.hours;
               minutes_in = cmd.minutes;
               seconds_in = cmd.seconds;
               day_in     = cmd.day;
               month_in   = cmd.month;
               year_in    = cmd.year;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      year_wday = (month_in <= MONTH_FEB) ? YEAR_WDAY_EARLY[year_in] : YEAR_WDAY_LATE[year_in];
      wday_sum  = {1'b0, day_in} + {3'b000, MONTH_WDAY[month_in]} + {3'b000, year_wday};

      rsp.hours   = hours_in;
      rsp.minutes = minutes_in;
      rsp.seconds = seconds_in;
      if (hours_in == '0) begin
         rsp.hours_twelve = 4'd12;
      end else if (hours_in > HOUR_NOON) begin
         rsp.hours_twelve = 4'(hours_in - HOUR_NOON);
      end else begin
         rsp.hours_twelve = hours_in[3:0];
      end
      rsp.is_pm   = (hours_in >= HOUR_NOON);
      rsp.day     = day_in;
      rsp.month   = month_in;
      rsp.year    = year_in;
      rsp.weekday = MOD7_TABLE[wday_sum];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hours_ff   <= '0;
         minutes_ff <= '0;
         seconds_ff <= '0;
         day_ff     <= DAY_FIRST;
         month_ff   <= MONTH_FIRST;
         year_ff    <= '0;
      end else begin
         hours_ff   <= hours_in;
         minutes_ff <= minutes_in;
         seconds_ff <= seconds_in;
         day_ff     <= day_in;
         month_ff   <= month_in;
         year_ff    <= year_in;
      end
   end

endmodule
`default_nettype wire

/* design/real_time_calendar_clock_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Real-time calendar clock unit
// Path: request, command queue, back-end state update, response queue.
// Rate: one per cycle while commands wait and the response queue has room.
// Reset: 00:00:00 on 1 January of year offset 0, both queues emptied.
// ----------------------------------------------------------------------------
module real_time_calendar_clock_unit #(
   parameter int CMD_DEPTH = 2,
   parameter int RSP_DEPTH = 2
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [2:0] req_action,
   input  wire logic [4:0] req_set_hours,
   input  wire logic [5:0] req_set_minutes,
   input  wire logic [5:0] req_set_seconds,
   input  wire logic [4:0] req_set_day,
   input  wire logic [3:0] req_set_month,
   input  wire logic [7:0] req_set_year,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [4:0]      rsp_hours,
   output logic [5:0]      rsp_minutes,
   output logic [5:0]      rsp_seconds,
   output logic [3:0]      rsp_hours_twelve,
   output logic            rsp_is_pm,
   output logic [4:0]      rsp_day,
   output logic [3:0]      rsp_month,
   output logic [7:0]      rsp_year,
   output logic [2:0]      rsp_weekday
);
   import rtc_pkg::*;

   cmd_type cmd_wr, cmd_rd;
   rsp_type rsp_wr, rsp_rd;
   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic    rsp_push, rsp_full;

   rtc_front u_front (
      .req_push        (req_push),
      .req_full        (req_full),
      .req_action      (req_action),
      .req_set_hours   (req_set_hours),
      .req_set_minutes (req_set_minutes),
      .req_set_seconds (req_set_seconds),
      .req_set_day     (req_set_day),
      .req_set_month   (req_set_month),
      .req_set_year    (req_set_year),
      .cmd_push        (cmd_push),
      .cmd             (cmd_wr),
      .cmd_full        (cmd_full)
   );

   rtc_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (cmd_empty)
   );

   rtc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd_rd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_wr)
   );

   rtc_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wr),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_rd),
      .empty   (rsp_empty)
   );

   assign rsp_hours        = rsp_rd.hours;
   assign rsp_minutes      = rsp_rd.minutes;
   assign rsp_seconds      = rsp_rd.seconds;
   assign rsp_hours_twelve = rsp_rd.hours_twelve;
   assign rsp_is_pm        = rsp_rd.is_pm;
   assign rsp_day          = rsp_rd.day;
   assign rsp_month        = rsp_rd.month;
   assign rsp_year         = rsp_rd.year;
   assign rsp_weekday      = rsp_rd.weekday;

endmodule
`default_nettype wire

/* tb/tb_calendar_pkg.sv */
// ----------------------------------------------------------------------------
// Calendar clock scoreboard
// Holds a cycle-free copy of the calendar state. Each accepted event advances
// it and queues the expected time report, which is matched against the
// responses as they leave the unit.
// ----------------------------------------------------------------------------
package tb_calendar_pkg;
   import rtc_pkg::*;

   localparam int SECONDS_PER_DAY  = 86400;
   localparam int SECONDS_PER_HOUR = 3600;
   localparam int MONTH_LEN [12]   = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   localparam int REPORT_LIMIT     = 10;

   typedef struct packed {
      logic [2:0] action;
      logic [4:0] set_hours;
      logic [5:0] set_minutes;
      logic [5:0] set_seconds;
      logic [4:0] set_day;
      logic [3:0] set_month;
      logic [7:0] set_year;
   } rtc_event_type;

   class rtc_calendar_checker;
      logic [16:0] sec_of_day;
      logic [4:0]  mday;
      logic [3:0]  mon;
      logic [7:0]  yoff;
      rsp_type     expected_reports [$];
      int          failures;

      function new();
         sec_of_day = '0;
         mday       = DAY_FIRST;
         mon        = MONTH_FIRST;
         yoff       = '0;
         failures   = 0;
      endfunction

      function bit is_leap(int full_year);
         return (full_year % 4 == 0) && ((full_year % 100 != 0) || (full_year % 400 == 0));
      endfunction

      function logic [4:0] month_days(logic [3:0] m, logic [7:0] yo);
         logic [3:0] mm;
         mm = (m < MONTH_FIRST) ? MONTH_FIRST : ((m > MONTH_LAST) ? MONTH_LAST : m);
         if (mm == MONTH_FEB && is_leap(BASE_YEAR + int'(yo))) begin
            return 5'd29;
         end
         return 5'(MONTH_LEN[mm - 1]);
      endfunction

      function void next_day();
         if (mday < month_days(mon, yoff)) begin
            mday++;
         end else begin
            mday = DAY_FIRST;
            if (mon >= MONTH_LAST) begin
               mon = MONTH_FIRST;
               yoff++;
            end else begin
               mon++;
            end
         end
      endfunction

      function void previous_day();
         if (mday > DAY_FIRST) begin
            mday--;
         end else begin
            if (mon <= MONTH_FIRST) begin
               mon = MONTH_LAST;
               yoff--;
            end else begin
               mon--;
            end
            mday = month_days(mon, yoff);
         end
      endfunction

      // Julian day number mod 7, Monday first
      function logic [2:0] weekday_now();
         int a;
         int y;
         int m;
         int jdn;
         a   = (14 - int'(mon)) / 12;
         y   = BASE_YEAR + int'(yoff) + 4800 - a;
         m   = int'(mon) + 12 * a - 3;
         jdn = int'(mday) + (153 * m + 2) / 5 + 365 * y + y / 4 - y / 100 + y / 400 - 32045;
         return 3'(jdn % 7);
      endfunction

      function rsp_type advance_calendar(rtc_event_type ev);
         rsp_type    r;
         int         sod;
         int         h;
         int         mi;
         logic [4:0] sh;
         logic [5:0] sm;
         logic [5:0] ss;
         logic [4:0] sd;
         logic [3:0] smo;
         logic [4:0] lim;
         sod = int'(sec_of_day);
         h   = sod / SECONDS_PER_HOUR;
         mi  = (sod % SECONDS_PER_HOUR) / 60;
         case (ev.action)
            ACT_TICK: begin
               sod++;
               if (sod >= SECONDS_PER_DAY) begin
                  sod -= SECONDS_PER_DAY;
                  next_day();
               end
            end
            ACT_MIN_UP: begin
               if (mi >= 59) begin
                  mi = 0;
                  h  = (h + 1) % 24;
               end else begin
                  mi++;
               end
               sod = h * SECONDS_PER_HOUR + mi * 60;
            end
            ACT_MIN_DOWN: begin
               if (mi == 0) begin
                  mi = 59;
                  h  = (h == 0) ? 23 : h - 1;
               end else begin
                  mi--;
               end
               sod = h * SECONDS_PER_HOUR + mi * 60;
            end
            ACT_DAY_UP: begin
               next_day();
            end
            ACT_DAY_DOWN: begin
               previous_day();
            end
            ACT_SET: begin
               sh  = (ev.set_hours > HOUR_LAST) ? HOUR_LAST : ev.set_hours;
               sm  = (ev.set_minutes > MINUTE_LAST) ? MINUTE_LAST : ev.set_minutes;
               ss  = (ev.set_seconds > MINUTE_LAST) ? MINUTE_LAST : ev.set_seconds;
               smo = (ev.set_month < MONTH_FIRST) ? MONTH_FIRST : ev.set_month;
               smo = (smo > MONTH_LAST) ? MONTH_LAST : smo;
               lim = month_days(smo, ev.set_year);
               sd  = (ev.set_day < DAY_FIRST) ? DAY_FIRST : ev.set_day;
               sd  = (sd > lim) ? lim : sd;
               sod  = int'(sh) * SECONDS_PER_HOUR + int'(sm) * 60 + int'(ss);
               mday = sd;
               mon  = smo;
               yoff = ev.set_year;
            end
            default: begin
            end
         endcase
         sec_of_day = 17'(sod);
         h  = sod / SECONDS_PER_HOUR;
         mi = (sod % SECONDS_PER_HOUR) / 60;
         r.hours        = 5'(h);
         r.minutes      = 6'(mi);
         r.seconds      = 6'(sod % 60);
         r.hours_twelve = 4'((h == 0) ? 12 : ((h > 12) ? h - 12 : h));
         r.is_pm        = (h >= 12);
         r.day          = mday;
         r.month        = mon;
         r.year         = yoff;
         r.weekday      = weekday_now();
         return r;
      endfunction

      function void note_event(rtc_event_type ev);
         expected_reports.push_back(advance_calendar(ev));
      endfunction

      function string report_text(rsp_type r);
         return $sformatf("%0d:%0d:%0d (%0d pm=%0d) %0d/%0d/+%0d wd=%0d",
                          r.hours, r.minutes, r.seconds, r.hours_twelve, r.is_pm,
                          r.day, r.month, r.year, r.weekday);
      endfunction

      function void log_failure(string msg);
         failures++;
         if (failures <= REPORT_LIMIT) begin
            $display("[%0t] %s", $realtime, msg);
         end
      endfunction

      function void check_report(rsp_type got);
         rsp_type exp;
         if (expected_reports.size() == 0) begin
            log_failure({"unexpected response ", report_text(got)});
            return;
         end
         exp = expected_reports.pop_front();
         if (got.hours !== exp.hours || got.minutes !== exp.minutes ||
             got.seconds !== exp.seconds || got.hours_twelve !== exp.hours_twelve ||
             got.is_pm !== exp.is_pm || got.day !== exp.day || got.month !== exp.month ||
             got.year !== exp.year || got.weekday !== exp.weekday) begin
            log_failure({"mismatch: expected ", report_text(exp), " got ", report_text(got)});
         end
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction
   endclass

endpackage

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Calendar clock unit testbench
// Directed events at the calendar edges, then randomised event sequences
// near day, month and year boundaries, with random gaps on both queues and
// one long response hold-off so that the unit back-pressures its input.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rtc_pkg::*;
   import tb_calendar_pkg::*;

   localparam int CLOCK_LIMIT  = 200000;
   localparam int RESET_CYCLES = 12;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_ITEMS = 450;
   localparam int CALM_ITEMS   = 60;
   localparam logic [2:0] ACT_SPARE_LO = 3'd6;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;
   localparam int EDGE_HOURS   [4] = '{0, 11, 12, 23};
   localparam int EDGE_MINUTES [4] = '{0, 1, 58, 59};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic [2:0] req_action = '0;
   logic [4:0] req_set_hours = '0;
   logic [5:0] req_set_minutes = '0;
   logic [5:0] req_set_seconds = '0;
   logic [4:0] req_set_day = '0;
   logic [3:0] req_set_month = '0;
   logic [7:0] req_set_year = '0;
   logic       rsp_pop = 1'b0;
   logic       req_full;
   logic       rsp_empty;
   logic [4:0] rsp_hours;
   logic [5:0] rsp_minutes;
   logic [5:0] rsp_seconds;
   logic [3:0] rsp_hours_twelve;
   logic       rsp_is_pm;
   logic [4:0] rsp_day;
   logic [3:0] rsp_month;
   logic [7:0] rsp_year;
   logic [2:0] rsp_weekday;

   logic hold_off = 1'b0;
   logic calm = 1'b0;
   int   accepted_count = 0;
   int   stall_left = 0;
   int   cycle_count = 0;

   rtc_calendar_checker cal_check = new();

   real_time_calendar_clock_unit DUT (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CLOCK_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response side: check, then decide the next pop
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            cal_check.check_report('{hours: rsp_hours, minutes: rsp_minutes,
                                     seconds: rsp_seconds, hours_twelve: rsp_hours_twelve,
                                     is_pm: rsp_is_pm, day: rsp_day, month: rsp_month,
                                     year: rsp_year, weekday: rsp_weekday});
         end
         if (hold_off) begin
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (!calm && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // long hold-off to fill the unit
   initial begin
      wait (accepted_count >= 150);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   function automatic rtc_event_type random_event(input logic [2:0] act);
      rtc_event_type ev;
      ev.action      = act;
      ev.set_hours   = 5'($urandom);
      ev.set_minutes = 6'($urandom);
      ev.set_seconds = 6'($urandom);
      ev.set_day     = 5'($urandom);
      ev.set_month   = 4'($urandom);
      ev.set_year    = 8'($urandom);
      return ev;
   endfunction

   function automatic rtc_event_type set_event(input int h, input int mi, input int s,
                                               input int d, input int mo, input int y);
      rtc_event_type ev;
      ev.action      = ACT_SET;
      ev.set_hours   = 5'(h);
      ev.set_minutes = 6'(mi);
      ev.set_seconds = 6'(s);
      ev.set_day     = 5'(d);
      ev.set_month   = 4'(mo);
      ev.set_year    = 8'(y);
      return ev;
   endfunction

   task automatic offer_event(input rtc_event_type ev);
      req_push        <= 1'b1;
      req_action      <= ev.action;
      req_set_hours   <= ev.set_hours;
      req_set_minutes <= ev.set_minutes;
      req_set_seconds <= ev.set_seconds;
      req_set_day     <= ev.set_day;
      req_set_month   <= ev.set_month;
      req_set_year    <= ev.set_year;
      do @(posedge clock); while (req_full);
      cal_check.note_event(ev);
      accepted_count++;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic offer_action(input logic [2:0] act);
      offer_event(random_event(act));
   endtask

   initial begin
      int total;
      int n;
      int mo;
      int d;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed edges
      offer_action(ACT_SPARE_LO);
      offer_action(ACT_SPARE_HI);
      offer_action(ACT_TICK);
      offer_action(ACT_MIN_DOWN);              // hour wraps below midnight
      offer_action(ACT_MIN_UP);
      offer_action(ACT_DAY_DOWN);              // year offset wraps below zero
      offer_action(ACT_DAY_UP);                // and back above 255
      offer_event(set_event(23, 59, 59, 31, 12, 255));
      offer_action(ACT_TICK);                  // midnight, new year, year wrap
      offer_event(set_event(11, 59, 59, 28, 2, 0));
      offer_action(ACT_TICK);                  // into the afternoon
      offer_event(set_event(23, 59, 59, 28, 2, 0));
      offer_action(ACT_TICK);                  // leap day in a 400 year
      offer_action(ACT_DAY_UP);
      offer_action(ACT_DAY_DOWN);
      offer_event(set_event(0, 0, 0, 29, 2, 100));   // century, not leap
      offer_action(ACT_DAY_UP);
      offer_event(set_event(31, 63, 63, 31, 15, 255)); // time fields and month saturate
      offer_event(set_event(0, 0, 0, 0, 0, 0));
      offer_event(set_event(23, 59, 30, 30, 4, 4));
      offer_action(ACT_MIN_UP);                // past midnight, date kept
      offer_action(ACT_DAY_UP);                // end of a 30-day month
      offer_event(set_event(13, 0, 0, 29, 2, 4));
      offer_action(ACT_TICK);

      total = accepted_count + RANDOM_ITEMS;
      while (accepted_count < total) begin
         if (accepted_count >= total - CALM_ITEMS) begin
            calm <= 1'b1;
         end
         case ($urandom_range(0, 4))
            0: begin
               // end of day into a month end
               if ($urandom_range(0, 3) == 0) begin
                  mo = 12;
                  d  = 31;
               end else begin
                  mo = $urandom_range(1, 12);
                  d  = $urandom_range(27, 31);
               end
               offer_event(set_event(23, 59, $urandom_range(55, 59), d, mo,
                                     $urandom_range(0, 255)));
               n = $urandom_range(1, 8);
               repeat (n) offer_action(ACT_TICK);
            end
            1: begin
               offer_action(ACT_SET);
               n = $urandom_range(1, 4);
               repeat (n) offer_action(3'($urandom_range(0, 7)));
            end
            2: begin
               offer_event(set_event(EDGE_HOURS[$urandom_range(0, 3)],
                                     EDGE_MINUTES[$urandom_range(0, 3)],
                                     $urandom_range(0, 59), $urandom_range(1, 31),
                                     $urandom_range(1, 12), $urandom_range(0, 255)));
               n = $urandom_range(1, 6);
               repeat (n) offer_action($urandom_range(0, 1) ? ACT_MIN_UP : ACT_MIN_DOWN);
            end
            3: begin
               offer_event(set_event($urandom_range(0, 23), $urandom_range(0, 59),
                                     $urandom_range(0, 59),
                                     $urandom_range(0, 1) ? 1 : 31,
                                     $urandom_range(1, 12), $urandom_range(0, 255)));
               n = $urandom_range(1, 8);
               repeat (n) offer_action(($urandom_range(0, 3) == 0) ? ACT_DAY_DOWN
                                                                   : ACT_DAY_UP);
            end
            default: begin
               n = $urandom_range(1, 4);
               repeat (n) offer_action(3'($urandom_range(0, 7)));
            end
         endcase
      end
      req_push <= 1'b0;

      while (cal_check.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (cal_check.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/rtc_pkg.sv
design/rtc_fifo.sv
design/rtc_front.sv
design/rtc_back.sv
design/real_time_calendar_clock_unit.sv
tb/tb_calendar_pkg.sv
tb/tb_top.sv
